// ----- rtl/core/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and register indexes of the serial frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 256;
	localparam int HEADER_BYTES        = 5;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 16;
	localparam int OUT_LEN_W  = 9;
	localparam int IDLE_W     = 21;
	localparam int LIMIT_W    = 20;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 20;
	localparam int S_DATA_W   = 8;
	localparam int S_USER_W   = 1;
	localparam int M_DATA_W   = 32;
	localparam int M_USER_W   = 2;

	localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT  = CFG_IDX_W'(3);

	localparam logic [7:0]         FIRST_SYNC_RST  = 8'd0;
	localparam logic [7:0]         SECOND_SYNC_RST = 8'd0;
	localparam logic [8:0]         MIN_LENGTH_RST  = 9'd5;
	localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST  = LIMIT_W'(1000);

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_POLL = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_WAIT  = 2'd1,
		PH_BODY  = 2'd2
	} phase_t;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic [7:0]         first_sync;
		logic [7:0]         second_sync;
		logic [8:0]         min_length;
		logic [LIMIT_W-1:0] idle_limit;
	} cfg_t;

	typedef struct packed {
		logic                 store_enable;
		logic [7:0]           store_index;
		logic [BYTE_W-1:0]    store_byte;
		logic                 frame_ready;
		logic [OUT_LEN_W-1:0] frame_length;
	} res_t;

endpackage

`default_nettype wire

// ----- rtl/core/serial_frame_receiver_unit.sv -----
// Path: a request passes the input register, the command queue and the result
// register before its result is presented. Throughput: one request per cycle
// unless the output stalls, set by the state update in the frame engine; the
// two-entry queue lets input and output stall independently.
// Reset: arst_n clears frame state and restores register defaults at once.
// ----------------------------------------------------------------------------
// serial_frame_receiver_unit
// Serial frame receiver with sync check, length parsing and idle timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver_unit #(
	parameter int MAX_FRAME_BYTES = sfr_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [sfr_pkg::S_DATA_W-1:0]     s_axis_tdata,  // [7:0] data_byte
	input  wire  [sfr_pkg::S_USER_W-1:0]     s_axis_tuser,  // [0] operation
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// [7:0] store_index, [15:8] store_byte, [24:16] frame_length, [31:25] zero
	output logic [sfr_pkg::M_DATA_W-1:0]     m_axis_tdata,
	// [0] store_enable, [1] frame_ready
	output logic [sfr_pkg::M_USER_W-1:0]     m_axis_tuser,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	sfr_pkg::cfg_t cfg_q;
	logic          push, queue_ready, q_valid, pop;
	sfr_pkg::cmd_t push_cmd, head;
	sfr_pkg::res_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_sync  <= sfr_pkg::FIRST_SYNC_RST;
			cfg_q.second_sync <= sfr_pkg::SECOND_SYNC_RST;
			cfg_q.min_length  <= sfr_pkg::MIN_LENGTH_RST;
			cfg_q.idle_limit  <= sfr_pkg::IDLE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfr_pkg::CFG_FIRST_SYNC:  cfg_q.first_sync  <= cfg_data[7:0];
				sfr_pkg::CFG_SECOND_SYNC: cfg_q.second_sync <= cfg_data[7:0];
				sfr_pkg::CFG_MIN_LENGTH:  cfg_q.min_length  <= cfg_data[8:0];
				sfr_pkg::CFG_IDLE_LIMIT:
					cfg_q.idle_limit <= cfg_data[sfr_pkg::LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sfr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_data     (s_axis_tdata),
		.in_user     (s_axis_tuser),
		.push        (push),
		.push_cmd    (push_cmd),
		.queue_ready (queue_ready)
	);

	sfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.ready    (queue_ready),
		.pop      (pop),
		.valid    (q_valid),
		.head     (head)
	);

	sfr_back #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (q_valid),
		.cmd       (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {7'd0, res.frame_length, res.store_byte, res.store_index};
	assign m_axis_tuser = {res.frame_ready, res.store_enable};

endmodule

`default_nettype wire

// ----- rtl/core/sfr_front.sv -----
// ----------------------------------------------------------------------------
// sfr_front
// Input stage: accepts stream requests, tags them as byte or poll and
// forwards them into the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_front (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [sfr_pkg::S_DATA_W-1:0]        in_data,
	input  wire  [sfr_pkg::S_USER_W-1:0]        in_user,
	output logic                                push,
	output sfr_pkg::cmd_t                       push_cmd,
	input  wire                                 queue_ready
);

	logic          valid_s1;
	sfr_pkg::cmd_t cmd_s1;
	logic          accept;

	assign in_ready = !valid_s1 || queue_ready;
	assign accept   = in_valid && in_ready;
	assign push     = valid_s1 && queue_ready;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op   <= in_user[0] ? sfr_pkg::OP_POLL : sfr_pkg::OP_BYTE;
			cmd_s1.data <= in_data[sfr_pkg::BYTE_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/sfr_queue.sv -----
// ----------------------------------------------------------------------------
// sfr_queue
// Two-entry command queue between the input stage and the frame engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  sfr_pkg::cmd_t  push_cmd,
	output logic           ready,
	input  wire            pop,
	output logic           valid,
	output sfr_pkg::cmd_t  head
);

	sfr_pkg::cmd_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign ready = (count_q != 2'd2);
	assign valid = (count_q != 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/sfr_back.sv -----
// ----------------------------------------------------------------------------
// sfr_back
// Frame engine: sync and length checks, byte counting, idle timeout and
// frame hand-over, with a registered result towards the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_back #(
	parameter int MAX_FRAME_BYTES = sfr_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  sfr_pkg::cfg_t  cfg,
	input  wire            cmd_valid,
	input  sfr_pkg::cmd_t  cmd,
	output logic           pop,
	output logic           out_valid,
	input  wire            out_ready,
	output sfr_pkg::res_t  out_res
);

	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int LEN_W = sfr_pkg::LEN_W;

	sfr_pkg::phase_t               phase_q, n_phase, base_ph;
	logic [CNT_W-1:0]              bc_q, n_bc, base_bc, bc1;
	logic [7:0]                    llb_q, n_llb;
	logic [LEN_W-1:0]              exp_q, n_exp, base_exp;
	logic [sfr_pkg::IDLE_W-1:0]    idle_q, n_idle, idle_base;
	logic                          wait_q, n_wait;
	logic                          pend_q, n_pend;
	logic [sfr_pkg::OUT_LEN_W-1:0] plen_q, n_plen;
	logic [LEN_W-1:0]              idx_w, bc1_w, len_field;
	logic                          clr_end;
	sfr_pkg::res_t                 res, res_q;
	logic                          valid_q;

	assign pop       = cmd_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_comb begin
		n_phase   = phase_q;
		n_bc      = bc_q;
		n_llb     = llb_q;
		n_exp     = exp_q;
		n_idle    = idle_q;
		n_wait    = wait_q;
		n_pend    = pend_q;
		n_plen    = plen_q;
		base_ph   = phase_q;
		base_bc   = bc_q;
		base_exp  = exp_q;
		bc1       = '0;
		idx_w     = '0;
		bc1_w     = '0;
		len_field = '0;
		idle_base = '0;
		clr_end   = 1'b0;
		res       = '0;

		if (cmd.op == sfr_pkg::OP_POLL) begin
			if (wait_q) begin
				idle_base = idle_q;
				if (idle_q >= sfr_pkg::IDLE_W'(cfg.idle_limit)) begin
					// drop the partial frame
					n_plen    = '0;
					n_bc      = '0;
					n_exp     = '0;
					n_wait    = 1'b0;
					n_phase   = sfr_pkg::PH_START;
					idle_base = '0;
				end
				n_idle = (idle_base == sfr_pkg::IDLE_MAX) ? idle_base
					: idle_base + sfr_pkg::IDLE_W'(1);
			end else begin
				n_bc    = '0;
				n_exp   = '0;
				n_idle  = '0;
				n_wait  = 1'b0;
				n_phase = sfr_pkg::PH_START;
			end
			if (pend_q) begin
				n_wait           = 1'b0;
				n_pend           = 1'b0;
				res.frame_ready  = 1'b1;
				res.frame_length = n_plen;
			end
		end else if (!pend_q) begin
			n_wait = 1'b1;
			n_idle = '0;
			if (bc_q >= CNT_W'(MAX_FRAME_BYTES)) begin
				// buffer overflow: restart at index zero
				base_bc  = '0;
				base_exp = '0;
				base_ph  = sfr_pkg::PH_START;
				n_wait   = 1'b0;
			end
			n_exp   = base_exp;
			n_phase = base_ph;
			idx_w   = LEN_W'(base_bc);
			res.store_enable = 1'b1;
			res.store_index  = idx_w[7:0];
			res.store_byte   = cmd.data;
			if (idx_w == LEN_W'(3)) begin
				n_llb = cmd.data;
			end
			bc1       = base_bc + CNT_W'(1);
			n_bc      = bc1;
			bc1_w     = LEN_W'(bc1);
			len_field = {cmd.data, llb_q};
			case (base_ph)
				sfr_pkg::PH_START: begin
					if (bc1_w == LEN_W'(1)) begin
						if (cmd.data != cfg.first_sync) begin
							clr_end = 1'b1;
						end
					end else if (bc1_w == LEN_W'(2)) begin
						if (cmd.data != cfg.second_sync) begin
							clr_end = 1'b1;
						end else begin
							n_phase = sfr_pkg::PH_WAIT;
						end
					end
				end
				sfr_pkg::PH_WAIT: begin
					if (bc1_w >= LEN_W'(sfr_pkg::HEADER_BYTES)) begin
						n_exp = len_field;
						if (len_field < LEN_W'(cfg.min_length) ||
						    len_field > LEN_W'(MAX_FRAME_BYTES)) begin
							clr_end = 1'b1;
						end else begin
							n_phase = sfr_pkg::PH_BODY;
						end
					end
				end
				sfr_pkg::PH_BODY: begin
					if (bc1_w == base_exp) begin
						n_pend  = 1'b1;
						n_plen  = bc1_w[sfr_pkg::OUT_LEN_W-1:0];
						clr_end = 1'b1;
					end else if (bc1_w > base_exp) begin
						clr_end = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (clr_end) begin
				n_bc    = '0;
				n_exp   = '0;
				n_idle  = '0;
				n_wait  = 1'b0;
				n_phase = sfr_pkg::PH_START;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfr_pkg::PH_START;
			bc_q    <= '0;
			llb_q   <= '0;
			exp_q   <= '0;
			idle_q  <= '0;
			wait_q  <= 1'b0;
			pend_q  <= 1'b0;
			plen_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= n_phase;
				bc_q    <= n_bc;
				llb_q   <= n_llb;
				exp_q   <= n_exp;
				idle_q  <= n_idle;
				wait_q  <= n_wait;
				pend_q  <= n_pend;
				plen_q  <= n_plen;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/sfr_checker.sv -----
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the serial frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            m_axis_tvalid,
	input wire                            m_axis_tready,
	input wire [sfr_pkg::M_DATA_W-1:0]    m_axis_tdata,
	input wire [sfr_pkg::M_USER_W-1:0]    m_axis_tuser
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// a byte store and a frame hand-over never share one result
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("store and frame hand-over in one result");

	a_store_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[15:0] == 16'd0)
		else $error("store fields set without store enable");

	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[31:16] == 16'd0)
		else $error("frame length set without frame ready");

endmodule

bind serial_frame_receiver_unit sfr_checker u_sfr_checker (.*);

`default_nettype wire
